[design/tcw_pkg.sv]
// tcw_pkg: shared sizes, codes and payload types of the text console writer
// no dependencies; used by tcw_ctrl and text_console_writer

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CELL_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(CELLS + 1);

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;
    localparam logic [CELL_W-1:0] ZERO_CELL    = 16'h0000;
    localparam logic [7:0]        NEWLINE_BYTE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    localparam logic [COL_W:0] COLS_V = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0] ROWS_V = (ROW_W + 1)'(ROWS);

    typedef enum logic [2:0] {
        ACT_APPEND_CELL = 3'd0,
        ACT_APPEND_CHAR = 3'd1,
        ACT_PUT_AT      = 3'd2,
        ACT_READ_AT     = 3'd3,
        ACT_CLEAR       = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RWAIT,
        S_SCROLL,
        S_FILL
    } t_state;

    typedef struct packed {
        logic [2:0]        action;
        logic [CELL_W-1:0] cell_req;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              end_of_write;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] read_cell;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
        logic              write_done;
    } t_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

[design/tcw_ram.sv]
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcw_ctrl.sv]
// tcw_ctrl: sequencer for the text console writer, cursor, sweeps and result register
// depends on tcw_pkg; drives the screen ram through a t_ram_req struct

module tcw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  tcw_pkg::t_req                 i_req,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attr,
    input  logic [tcw_pkg::CELL_W-1:0]    i_rdata,
    output tcw_pkg::t_ram_req             o_ram,
    output logic                          o_busy,
    output logic                          o_strobe,
    output tcw_pkg::t_rsp                 o_rsp
);

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_req   r_req;
    tcw_pkg::t_rsp   r_rsp, n_rsp;

    logic [tcw_pkg::ROW_W-1:0] r_cur_row, n_cur_row;
    logic [tcw_pkg::COL_W-1:0] r_cur_col, n_cur_col;
    logic [tcw_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_from_cmd, n_from_cmd;
    logic                      r_strobe, n_strobe;

    logic [tcw_pkg::CELL_W-1:0] app_cell;
    logic                       is_append;
    logic                       is_newline;
    logic [tcw_pkg::COL_W:0]    col_inc;
    logic [tcw_pkg::ROW_W:0]    row_inc;
    logic                       col_wrap;
    logic                       need_scroll;
    logic                       in_range;
    logic [tcw_pkg::ADDR_W-1:0] cur_addr;
    logic [tcw_pkg::ADDR_W-1:0] place_addr;
    logic                       idx_last;

    assign app_cell = (r_req.action == tcw_pkg::ACT_APPEND_CHAR)
                    ? {i_attr, r_req.cell_req[7:0]} : r_req.cell_req;
    assign is_append = (r_req.action == tcw_pkg::ACT_APPEND_CELL)
                    || (r_req.action == tcw_pkg::ACT_APPEND_CHAR);
    assign is_newline = (app_cell[7:0] == tcw_pkg::NEWLINE_BYTE);
    assign col_inc = {1'b0, r_cur_col} + 1'b1;
    assign row_inc = {1'b0, r_cur_row} + 1'b1;
    assign col_wrap = (col_inc >= tcw_pkg::COLS_V);
    // a newline or a wrap on the bottom row runs off the screen
    assign need_scroll = (is_newline || col_wrap) && (row_inc == tcw_pkg::ROWS_V);
    assign in_range = (32'(r_req.column) < tcw_pkg::COLUMNS)
                   && (32'(r_req.row) < tcw_pkg::ROWS);
    assign cur_addr = tcw_pkg::ADDR_W'(r_cur_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(r_cur_col);
    assign place_addr = tcw_pkg::ADDR_W'(r_req.row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                      + tcw_pkg::ADDR_W'(r_req.column);
    assign idx_last = (r_idx == tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::S_CLEAR: begin
                if (idx_last) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC: begin
                n_state = tcw_pkg::S_IDLE;
                case (r_req.action) inside
                    tcw_pkg::ACT_APPEND_CELL, tcw_pkg::ACT_APPEND_CHAR: begin
                        if (need_scroll) begin
                            n_state = tcw_pkg::S_SCROLL;
                        end
                    end
                    tcw_pkg::ACT_READ_AT: begin
                        if (in_range) begin
                            n_state = tcw_pkg::S_RWAIT;
                        end
                    end
                    tcw_pkg::ACT_CLEAR: n_state = tcw_pkg::S_CLEAR;
                    default: n_state = tcw_pkg::S_IDLE;
                endcase
            end
            tcw_pkg::S_RWAIT: n_state = tcw_pkg::S_IDLE;
            tcw_pkg::S_SCROLL: begin
                if (r_idx == tcw_pkg::IDX_W'(tcw_pkg::CELLS)) begin
                    n_state = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_FILL: begin
                if (idx_last) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // datapath, memory access and result
    always_comb begin
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_idx      = r_idx;
        n_from_cmd = r_from_cmd;
        n_strobe   = 1'b0;
        n_rsp      = r_rsp;
        o_ram      = '0;

        unique case (r_state)
            tcw_pkg::S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[tcw_pkg::ADDR_W-1:0];
                o_ram.wdata = tcw_pkg::BLANK_CELL;
                n_idx       = r_idx + 1'b1;
                if (idx_last) begin
                    n_strobe = r_from_cmd;
                end
            end
            tcw_pkg::S_IDLE: begin
                n_idx = '0;
            end
            tcw_pkg::S_EXEC: begin
                n_strobe = 1'b1;
                case (r_req.action) inside
                    tcw_pkg::ACT_APPEND_CELL, tcw_pkg::ACT_APPEND_CHAR: begin
                        if (is_newline || col_wrap) begin
                            n_cur_col = '0;
                            n_cur_row = need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                                    : row_inc[tcw_pkg::ROW_W-1:0];
                        end else begin
                            n_cur_col = col_inc[tcw_pkg::COL_W-1:0];
                        end
                        if (!is_newline) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = cur_addr;
                            o_ram.wdata = app_cell;
                        end
                        if (need_scroll) begin
                            n_strobe = 1'b0;
                            n_idx    = tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
                        end
                    end
                    tcw_pkg::ACT_PUT_AT: begin
                        o_ram.we    = in_range;
                        o_ram.waddr = place_addr;
                        o_ram.wdata = r_req.cell_req;
                    end
                    tcw_pkg::ACT_READ_AT: begin
                        o_ram.re    = in_range;
                        o_ram.raddr = place_addr;
                        n_strobe    = !in_range;
                    end
                    tcw_pkg::ACT_CLEAR: begin
                        n_strobe   = 1'b0;
                        n_cur_row  = '0;
                        n_cur_col  = '0;
                        n_idx      = '0;
                        n_from_cmd = 1'b1;
                    end
                    default: n_strobe = 1'b1;
                endcase
                n_rsp.read_cell     = tcw_pkg::ZERO_CELL;
                n_rsp.cursor_row    = n_cur_row;
                n_rsp.cursor_column = n_cur_col;
                n_rsp.scrolled      = need_scroll && is_append;
                n_rsp.write_done    = r_req.end_of_write;
            end
            tcw_pkg::S_RWAIT: begin
                n_strobe        = 1'b1;
                n_rsp.read_cell = i_rdata;
            end
            tcw_pkg::S_SCROLL: begin
                // read one cell ahead, write the previous read one row up
                o_ram.re    = (r_idx != tcw_pkg::IDX_W'(tcw_pkg::CELLS));
                o_ram.raddr = r_idx[tcw_pkg::ADDR_W-1:0];
                o_ram.we    = (r_idx != tcw_pkg::IDX_W'(tcw_pkg::COLUMNS));
                o_ram.waddr = tcw_pkg::ADDR_W'(r_idx - tcw_pkg::IDX_W'(tcw_pkg::COLUMNS + 1));
                o_ram.wdata = i_rdata;
                if (r_idx == tcw_pkg::IDX_W'(tcw_pkg::CELLS)) begin
                    n_idx = tcw_pkg::IDX_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tcw_pkg::S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx[tcw_pkg::ADDR_W-1:0];
                o_ram.wdata = tcw_pkg::ZERO_CELL;
                n_idx       = r_idx + 1'b1;
                n_strobe    = idx_last;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcw_pkg::S_CLEAR;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_idx      <= '0;
            r_from_cmd <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_idx      <= n_idx;
            r_from_cmd <= n_from_cmd;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (r_state == tcw_pkg::S_IDLE && i_start) begin
            r_req <= i_req;
        end
    end

    assign o_busy   = (r_state != tcw_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

[design/text_console_writer.sv]
// text console writer: 80x25 screen of 16-bit cells with cursor, wrap and scroll
// depends on tcw_pkg, tcw_ram and tcw_ctrl
// append, put and unused actions have their strobe registered out of the EXEC state, a read out of RWAIT
// (out of EXEC for a read off the screen); a new command is taken only while busy is low
// a scroll (SCROLL then FILL) and a clear (CLEAR) keep busy high, both paced by the single write port
// reset: a clearing pass over all CELLS (2000) cells blanks the ram, busy stays high

module text_console_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tcw_pkg::t_req               i_req,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    output logic                        o_strobe,
    output tcw_pkg::t_rsp               o_rsp
);

    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    tcw_pkg::t_ram_req          ram_req;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_attr   (r_attr),
        .i_rdata  (ram_rdata),
        .o_ram    (ram_req),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted without going busy");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_rsp.cursor_row) < tcw_pkg::ROWS)
                  && (32'(o_rsp.cursor_column) < tcw_pkg::COLUMNS))
        else $error("cursor out of screen");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.scrolled |->
            (o_rsp.cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
            && (o_rsp.cursor_column == '0))
        else $error("scroll left cursor off the bottom row start");

endmodule
